[sv/bpc_pkg.sv]
`timescale 1ns / 1ps
// Package for the barometric pressure compensation unit.
// Holds register indexes, widths, arithmetic constants and the result struct; no dependencies.
package bpc_pkg;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned RawW = 24;
  localparam int unsigned ValW = 32;

  localparam logic [CfgIdxW-1:0] RegCalA = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCalB = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCalC = 2'd2;
  localparam logic [CfgIdxW-1:0] RegOss = 2'd3;

  localparam logic [ValW-1:0] KB6Off = 32'd4000;
  localparam logic [ValW-1:0] KHalf = 32'd32768;
  localparam logic [ValW-1:0] KBase = 32'd50000;
  localparam logic [ValW-1:0] KTop = 32'h8000_0000;
  localparam logic [ValW-1:0] KC1 = 32'd3038;
  localparam logic [ValW-1:0] KC2 = 32'hFFFF_E343;
  localparam logic [ValW-1:0] KC3 = 32'd3791;

  typedef struct packed {
    logic kind;
    logic [ValW-1:0] value;
    logic err;
  } res_t;
endpackage

[sv/bpc_if.sv]
`timescale 1ns / 1ps
// Handshake interfaces for the request and result channels.
// Depends on bpc_pkg for the payload widths.
interface bpc_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic [bpc_pkg::RawW-1:0] raw_reading;
  modport source(output valid, req_type, raw_reading, input ready);
  modport sink(input valid, req_type, raw_reading, output ready);
endinterface

interface bpc_res_if;
  logic valid;
  logic ready;
  logic result_kind;
  logic signed [bpc_pkg::ValW-1:0] compensated_value;
  logic divide_error;
  modport source(output valid, result_kind, compensated_value, divide_error, input ready);
  modport sink(input valid, result_kind, compensated_value, divide_error, output ready);
endinterface

[sv/barometric_pressure_compensation_unit.sv]
`timescale 1ns / 1ps
// Top level of the barometric pressure compensation unit.
// Depends on bpc_pkg and the interfaces in bpc_if.
//
// channel   dir  payload
// req       in   req_type, raw_reading
// res       out  result_kind, compensated_value, divide_error
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// A temperature transaction makes one pass of the shared 32-bit multiplier and a
// pressure transaction seven. A one-bit-a-cycle divider follows, pressure then
// makes three more passes, and the result goes to the output register. A zero
// divisor skips the divider and any further passes.
// The result waits in that register; the next request is taken the cycle after
// it has been handed over. Reset clears all registers, the calibration and B5.
module barometric_pressure_compensation_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bpc_pkg::CfgDataW-1:0]  cfg_data_i,
  bpc_req_if.sink                       req,
  bpc_res_if.source                     res
);
  import bpc_pkg::*;

  localparam logic [4:0] SIdle = 5'd0, SMul = 5'd1, SDiv = 5'd2, SOut = 5'd3;

  logic [63:0] cal_a_q, cal_b_q;
  logic [47:0] cal_c_q;
  logic [1:0]  oss_q;
  logic [31:0] b5_q;
  logic [4:0]  st_q;
  logic [4:0]  step_q;
  logic        kind_q;
  logic [23:0] raw_q;
  logic [31:0] r0_q, r1_q, r2_q, r3_q, r4_q, r5_q;
  logic [31:0] ma, mb, prod;
  logic [31:0] dq_q, drem_q, dd_q, dn_q;
  logic [5:0]  dcnt_q;
  logic        dneg_q;
  logic [32:0] dsub;
  res_t        res_q;
  logic        rvalid_q;

  function automatic logic [31:0] sx(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
    return $unsigned($signed(v) >>> s);
  endfunction

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx(cal_a_q[63:48]);
  assign ac2 = sx(cal_a_q[47:32]);
  assign ac3 = sx(cal_a_q[31:16]);
  assign ac4 = {16'd0, cal_a_q[15:0]};
  assign ac5 = {16'd0, cal_b_q[63:48]};
  assign ac6 = {16'd0, cal_b_q[47:32]};
  assign b1  = sx(cal_b_q[31:16]);
  assign b2  = sx(cal_b_q[15:0]);
  assign mc  = sx(cal_c_q[31:16]);
  assign md  = sx(cal_c_q[15:0]);

  // Multiplier operand selection per step.
  always_comb begin
    ma = r0_q;
    mb = r0_q;
    if (!kind_q) begin
      ma = {16'd0, raw_q[15:0]} - ac6;
      mb = ac5;
    end else begin
      case (step_q)
        5'd0: begin ma = r0_q; mb = r0_q; end
        5'd1: begin ma = b2;   mb = r1_q; end
        5'd2: begin ma = ac2;  mb = r0_q; end
        5'd3: begin ma = ac3;  mb = r0_q; end
        5'd4: begin ma = b1;   mb = r1_q; end
        5'd5: begin ma = ac4;  mb = r4_q; end
        5'd6: begin ma = r3_q; mb = KBase >> oss_q; end
        5'd7: begin ma = asr(r5_q, 8); mb = asr(r5_q, 8); end
        5'd8: begin ma = r4_q; mb = KC1; end
        default: begin ma = KC2; mb = r5_q; end
      endcase
    end
  end
  assign prod = ma * mb;
  assign dsub = {drem_q, dn_q[31]} - {1'b0, dd_q};

  logic [31:0] upv, tnum, tden, dquo, b5_new;
  assign upv = {8'd0, raw_q} >> (4'd8 - {2'd0, oss_q});
  assign tnum = mc << 11;
  assign tden = asr(prod, 15) + md;
  assign dquo = {dq_q[30:0], !dsub[32]};
  assign b5_new = r1_q + (dneg_q ? -dquo : dquo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_a_q <= '0; cal_b_q <= '0; cal_c_q <= '0; oss_q <= '0; b5_q <= '0;
      st_q <= SIdle; step_q <= '0; rvalid_q <= 1'b0; dcnt_q <= '0;
      kind_q <= 1'b0; raw_q <= '0; res_q <= '0;
      r0_q <= '0; r1_q <= '0; r2_q <= '0; r3_q <= '0; r4_q <= '0; r5_q <= '0;
      dq_q <= '0; drem_q <= '0; dd_q <= '0; dn_q <= '0; dneg_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegCalA: cal_a_q <= cfg_data_i;
          RegCalB: cal_b_q <= cfg_data_i;
          RegCalC: cal_c_q <= cfg_data_i[47:0];
          RegOss:  oss_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (rvalid_q && res.ready) rvalid_q <= 1'b0;
      unique case (st_q)
        SIdle: if (req.valid && !rvalid_q) begin
          kind_q <= req.req_type;
          raw_q <= req.raw_reading;
          r0_q <= b5_q - KB6Off;
          step_q <= '0;
          st_q <= SMul;
        end
        SMul: begin
          step_q <= step_q + 5'd1;
          if (!kind_q) begin
            r1_q <= asr(prod, 15);
            if (tden == '0) begin
              res_q <= '{kind: 1'b0, value: '0, err: 1'b1};
              st_q <= SOut;
            end else begin
              dn_q <= tnum[31] ? -tnum : tnum;
              dd_q <= tden[31] ? -tden : tden;
              dneg_q <= tnum[31] ^ tden[31];
              st_q <= SDiv;
            end
          end else begin
            case (step_q)
              5'd0: r1_q <= asr(prod, 12);
              5'd1: r2_q <= asr(prod, 11);
              5'd2: r2_q <= r2_q + asr(prod, 11);
              5'd3: begin
                r3_q <= asr((((ac1 << 2) + r2_q) << oss_q) + 32'd2, 2);
                r2_q <= asr(prod, 13);
              end
              5'd4: r4_q <= asr(r2_q + asr(prod, 16) + 32'd2, 2) + KHalf;
              5'd5: begin
                r4_q <= prod >> 15;
                r3_q <= upv - r3_q;
              end
              5'd6: begin
                if (r4_q == '0) begin
                  res_q <= '{kind: 1'b1, value: '0, err: 1'b1};
                  st_q <= SOut;
                end else begin
                  dd_q <= r4_q;
                  dneg_q <= (prod >= KTop);
                  dn_q <= (prod < KTop) ? (prod << 1) : prod;
                  st_q <= SDiv;
                end
              end
              5'd7: r4_q <= prod;
              5'd8: r4_q <= asr(prod, 16);
              default: begin
                res_q <= '{kind: 1'b1,
                           value: r5_q + asr(r4_q + asr(prod, 16) + KC3, 4),
                           err: 1'b0};
                st_q <= SOut;
              end
            endcase
          end
          if (!kind_q || step_q == 5'd6) begin
            dcnt_q <= '0; drem_q <= '0; dq_q <= '0;
          end
        end
        SDiv: begin
          if (!dsub[32]) begin
            drem_q <= dsub[31:0]; dq_q <= {dq_q[30:0], 1'b1};
          end else begin
            drem_q <= {drem_q[30:0], dn_q[31]}; dq_q <= {dq_q[30:0], 1'b0};
          end
          dn_q <= dn_q << 1;
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'd31) begin
            if (!kind_q) begin
              b5_q <= b5_new;
              res_q <= '{kind: 1'b0, value: asr(b5_new + 32'd8, 4), err: 1'b0};
              st_q <= SOut;
            end else begin
              r5_q <= dneg_q ? (dquo << 1) : dquo;
              st_q <= SMul;
            end
          end
        end
        SOut: begin
          rvalid_q <= 1'b1;
          st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  assign req.ready = (st_q == SIdle) && !rvalid_q;
  assign res.valid = rvalid_q;
  assign res.result_kind = res_q.kind;
  assign res.compensated_value = $signed(res_q.value);
  assign res.divide_error = res_q.err;

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != SIdle) |-> !req.ready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rvalid_q && !res.ready) |=> $stable(res_q)) else $error("result changed");
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rvalid_q && res_q.err) |-> (res_q.value == '0)) else $error("error value");
endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for barometric_pressure_compensation_unit.
// Drives request transactions and checks each result against a bit-accurate predictor.
// Depends on bpc_pkg and the interfaces in bpc_if.
module tb_top;
  import bpc_pkg::*;

  typedef struct packed {
    logic kind;
    logic [RawW-1:0] raw;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  bpc_req_if req ();
  bpc_res_if res ();

  barometric_pressure_compensation_unit u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req(req.sink),
    .res(res.source)
  );

  always #1 clk_i = ~clk_i;

  reading_t pending_readings[$];
  res_t expected_results[$];
  logic [63:0] cal_a = '0, cal_b = '0;
  logic [47:0] cal_c = '0;
  logic [1:0] oss = '0;
  logic [31:0] b5 = '0;
  bit failed = 1'b0;
  bit no_idle = 1'b0;
  bit req_fire = 1'b0;
  int unsigned req_gap = 0, res_gap = 0, quiet_cycles = 0;

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sra(logic [31:0] v, int unsigned s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic res_t compensate(reading_t it);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, den, b6, sq, b3, b4, b7, p, b5_n;
    res_t r;
    ac1 = sx16(cal_a[63:48]);
    ac2 = sx16(cal_a[47:32]);
    ac3 = sx16(cal_a[31:16]);
    ac4 = {16'd0, cal_a[15:0]};
    ac5 = {16'd0, cal_b[63:48]};
    ac6 = {16'd0, cal_b[47:32]};
    b1 = sx16(cal_b[31:16]);
    b2 = sx16(cal_b[15:0]);
    mc = sx16(cal_c[31:16]);
    md = sx16(cal_c[15:0]);
    r.kind = it.kind;
    r.value = '0;
    r.err = 1'b0;
    if (!it.kind) begin
      ut = {16'd0, it.raw[15:0]};
      x1 = sra((ut - ac6) * ac5, 15);
      den = x1 + md;
      if (den == '0) begin
        r.err = 1'b1;
      end else begin
        x2 = sdiv(mc << 11, den);
        b5_n = x1 + x2;
        b5 = b5_n;
        r.value = sra(b5_n + 32'd8, 4);
      end
    end else begin
      up = {8'd0, it.raw} >> (4'd8 - oss);
      b6 = b5 - KB6Off;
      sq = sra(b6 * b6, 12);
      x1 = sra(b2 * sq, 11);
      x2 = sra(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = sra(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
      x1 = sra(ac3 * b6, 13);
      x2 = sra(b1 * sq, 16);
      x3 = sra(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + KHalf)) >> 15;
      b7 = (up - b3) * (KBase >> oss);
      if (b4 == '0) begin
        r.err = 1'b1;
      end else begin
        if (b7 < KTop) p = (b7 << 1) / b4;
        else p = (b7 / b4) << 1;
        x1 = sra(p, 8) * sra(p, 8);
        x1 = sra(x1 * KC1, 16);
        x2 = sra(KC2 * p, 16);
        r.value = p + sra(x1 + x2 + KC3, 4);
      end
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  always @(negedge clk_i or negedge rst_ni) begin
    reading_t it;
    if (!rst_ni) begin
      req.valid <= 1'b0;
      req.req_type <= 1'b0;
      req.raw_reading <= '0;
    end else if (!req.valid || req_fire) begin
      if (req_gap != 0) begin
        req_gap--;
        req.valid <= 1'b0;
      end else if (pending_readings.size() != 0) begin
        it = pending_readings.pop_front();
        req.valid <= 1'b1;
        req.req_type <= it.kind;
        req.raw_reading <= it.raw;
        req_gap = pick_gap();
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else if (res_gap != 0) begin
      res_gap--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
      res_gap = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    req_fire <= req.valid && req.ready;
    if (rst_ni) begin
      if ((req.valid && req.ready) || (res.valid && res.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (req.valid && req.ready) begin
        expected_results.push_back(compensate({req.req_type, req.raw_reading}));
      end
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: value %0d", res.compensated_value);
          failed = 1'b1;
        end else begin
          want = expected_results.pop_front();
          if (res.result_kind !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, res.result_kind);
            failed = 1'b1;
          end
          if (res.compensated_value !== want.value) begin
            $error("compensated_value: expected %0d, got %0d",
                   $signed(want.value), res.compensated_value);
            failed = 1'b1;
          end
          if (res.divide_error !== want.err) begin
            $error("divide_error: expected %0d, got %0d", want.err, res.divide_error);
            failed = 1'b1;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= 5000) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_readings.size() != 0 || expected_results.size() != 0 || req.valid)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic configure(logic [63:0] a, logic [63:0] b, logic [63:0] c, logic [1:0] o);
    wait_idle();
    write_reg(RegCalA, a);
    write_reg(RegCalB, b);
    write_reg(RegCalC, c);
    write_reg(RegOss, {62'd0, o});
    cal_a = a;
    cal_b = b;
    cal_c = c[47:0];
    oss = o;
  endtask

  task automatic add(logic kind, logic [RawW-1:0] raw);
    pending_readings.push_back({kind, raw});
  endtask

  task automatic add_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: add(1'b0, {8'($urandom_range(0, 255)), 16'($urandom_range(20000, 36000))});
        1: add(1'b1, RawW'($urandom_range(18000, 26000)) << 8 | RawW'($urandom_range(0, 255)));
        default: add(1'($urandom_range(0, 1)), RawW'($urandom));
      endcase
    end
  endtask

  localparam logic [63:0] CalAData = {16'd408, 16'hFFB8, 16'hC7D1, 16'd32741};
  localparam logic [63:0] CalBData = {16'd32757, 16'd23153, 16'd6190, 16'd4};
  localparam logic [63:0] CalCData = {16'hABCD, 16'h8000, 16'hDDE9, 16'd2868};

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Pressure before any temperature, with every register at reset.
    add(1'b1, 24'h000000);
    add(1'b0, 24'h000000);
    add(1'b0, 24'hFFFFFF);
    add(1'b1, 24'hFFFFFF);

    configure(CalAData, CalBData, CalCData, 2'd0);
    add(1'b0, 24'h006CFA);
    add(1'b1, 24'h5D2300);
    add(1'b1, 24'hFFFFFF);
    add(1'b1, 24'h000000);
    add(1'b0, 24'hFF6CFA);
    add(1'b0, 24'h00FFFF);

    // Temperature divisor of zero must leave B5 as it was.
    configure({48'd0, 16'd32741}, {16'h8000, 16'd1000, 32'd0},
              {32'hFFFF_0000, 16'h0000, 16'hFF9C}, 2'd3);
    add(1'b0, 24'h00044B);
    add(1'b0, 24'h00044C);
    add(1'b1, 24'h123456);
    add(1'b0, 24'h000000);
    add(1'b1, 24'h800000);

    // Pressure divisor of zero.
    configure({48'h7FFF_8000_7FFF, 16'd0}, CalBData, CalCData, 2'd2);
    add(1'b0, 24'h006CFA);
    add(1'b1, 24'h5D2300);

    configure('1, '1, '1, 2'd3);
    add(1'b0, 24'hFFFFFF);
    add(1'b1, 24'hFFFFFF);
    add(1'b1, 24'h000000);

    for (int unsigned ph = 0; ph < 8; ph++) begin
      no_idle = (ph % 3 == 2);
      case (ph)
        0, 1, 2, 3: configure(CalAData, CalBData, {$urandom, $urandom} & ~64'h0 |
                              {16'd0, CalCData[47:0]} , 2'(ph));
        4: configure('0, '0, '0, 2'd0);
        5: configure('1, CalBData, CalCData, 2'd1);
        default: configure({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, 2'($urandom));
      endcase
      add_random(ph >= 6 ? 285 : 160);
    end
    no_idle = 1'b0;

    while (pending_readings.size() != 0 || expected_results.size() != 0 || req.valid)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (!failed) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
